FILE: hdl/bgbp_pkg.sv
// ----------------------------------------------------------------------------
// bgbp_pkg: shared types and constants
// widths, outcome codes, register indexes and controller command struct
// ----------------------------------------------------------------------------
package bgbp_pkg;

  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned COST_W       = 4;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned BTB_ENTRIES  = 64;
  localparam int unsigned HISTORY_BITS = 4;

  localparam logic [COST_W-1:0] PLAIN_COST_RST      = 4'd1;
  localparam logic [COST_W-1:0] HIT_COST_RST        = 4'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST       = 4'd5;
  localparam logic [COST_W-1:0] MISPREDICT_COST_RST = 4'd4;

  typedef enum logic [1:0] {
    OUT_NONBRANCH = 2'd0,
    OUT_HIT       = 2'd1,
    OUT_MISS      = 2'd2,
    OUT_MISPRED   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    REG_PLAIN      = 2'd0,
    REG_HIT        = 2'd1,
    REG_MISS       = 2'd2,
    REG_MISPREDICT = 2'd3
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input transaction, launch btb read
    logic resolve; // evaluate, update tables and totals, fill output
  } dp_cmd_t;

endpackage

FILE: hdl/bgbp_ctrl.sv
// ----------------------------------------------------------------------------
// bgbp_ctrl: controller
// sequences load, table read and resolve for one transaction at a time
// ----------------------------------------------------------------------------
module bgbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  output bgbp_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_READ    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  // output register free now or being emptied this cycle
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.resolve = (state_r == ST_RESOLVE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_RESOLVE;
      ST_RESOLVE: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hdl/bgbp_dp.sv
// ----------------------------------------------------------------------------
// bgbp_dp: datapath
// btb memories, valid bits, history, pattern counters, totals, output register
// ----------------------------------------------------------------------------
module bgbp_dp #(
  parameter int unsigned BTB_ENTRIES  = bgbp_pkg::BTB_ENTRIES,
  parameter int unsigned HISTORY_BITS = bgbp_pkg::HISTORY_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bgbp_pkg::dp_cmd_t                  cmd,
  input  logic [bgbp_pkg::ADDR_W-1:0]        in_instr_address,
  input  logic [bgbp_pkg::LEN_W-1:0]         in_instr_length,
  input  logic                               in_is_branch,
  input  logic                               in_is_conditional,
  input  logic [bgbp_pkg::ADDR_W-1:0]        in_actual_next,
  input  logic                               cfg_valid,
  input  logic [bgbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgbp_pkg::COST_W-1:0]        cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [1:0]                         out_outcome,
  output logic [bgbp_pkg::COST_W-1:0]        out_cost,
  output logic [bgbp_pkg::SUM_W-1:0]         out_total_cycles,
  output logic [bgbp_pkg::SUM_W-1:0]         out_total_hit,
  output logic [bgbp_pkg::SUM_W-1:0]         out_total_miss,
  output logic [bgbp_pkg::SUM_W-1:0]         out_total_mispredict
);

  localparam int unsigned IDX_W = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
  localparam int unsigned PHT_N = 1 << HISTORY_BITS;
  localparam int unsigned AW    = bgbp_pkg::ADDR_W;
  localparam int unsigned CW    = bgbp_pkg::COST_W;
  localparam int unsigned SW    = bgbp_pkg::SUM_W;

  // configuration registers
  logic [CW-1:0] plain_cost_r, hit_cost_r, miss_cost_r, mispred_cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_cost_r   <= bgbp_pkg::PLAIN_COST_RST;
      hit_cost_r     <= bgbp_pkg::HIT_COST_RST;
      miss_cost_r    <= bgbp_pkg::MISS_COST_RST;
      mispred_cost_r <= bgbp_pkg::MISPREDICT_COST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bgbp_pkg::REG_PLAIN:      plain_cost_r   <= cfg_data;
        bgbp_pkg::REG_HIT:        hit_cost_r     <= cfg_data;
        bgbp_pkg::REG_MISS:       miss_cost_r    <= cfg_data;
        bgbp_pkg::REG_MISPREDICT: mispred_cost_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [AW-1:0]   addr_r, next_r, fall_r;
  logic            br_r, cond_r;
  logic [IDX_W-1:0] slot;

  assign slot = addr_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_instr_address;
      next_r <= in_actual_next;
      fall_r <= in_instr_address + AW'(in_instr_length);
      br_r   <= in_is_branch;
      cond_r <= in_is_conditional;
    end
  end

  // btb storage, registered reads
  logic [AW-1:0] tag_mem [BTB_ENTRIES];
  logic [AW-1:0] tgt_mem [BTB_ENTRIES];
  logic [BTB_ENTRIES-1:0] valid_r;
  logic [AW-1:0] tag_rd_r, tgt_rd_r;
  logic          vld_rd_r;
  logic [IDX_W-1:0] rd_idx;

  assign rd_idx = in_instr_address[IDX_W-1:0];

  logic tag_we, tgt_we;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_rd_r <= tag_mem[rd_idx];
      tgt_rd_r <= tgt_mem[rd_idx];
    end
    if (tag_we) tag_mem[slot] <= addr_r;
    if (tgt_we) tgt_mem[slot] <= next_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (cmd.load) vld_rd_r <= valid_r[rd_idx];
      if (tag_we)   valid_r[slot] <= 1'b1;
    end
  end

  // direction predictor
  logic [HISTORY_BITS-1:0] hist_r;
  logic [1:0]              pht_r [PHT_N];
  logic [HISTORY_BITS-1:0] pidx;
  logic [1:0]              ctr, ctr_upd;

  assign pidx = hist_r ^ addr_r[HISTORY_BITS-1:0];
  assign ctr  = pht_r[pidx];

  // resolve
  logic          taken, btb_hit, cond_upd;
  logic [AW-1:0] predicted;
  logic [1:0]    outcome;
  logic [CW-1:0] cost;

  assign taken     = (next_r != fall_r);
  assign btb_hit   = vld_rd_r && (tag_rd_r == addr_r);
  assign predicted = ctr[1] ? tgt_rd_r : fall_r;
  assign cond_upd  = br_r && btb_hit && cond_r;

  always_comb begin
    ctr_upd = ctr;
    if (taken && ctr != 2'd3)       ctr_upd = ctr + 2'd1;
    else if (!taken && ctr != 2'd0) ctr_upd = ctr - 2'd1;
  end

  always_comb begin
    tag_we = 1'b0;
    tgt_we = 1'b0;
    if (!br_r) begin
      outcome = bgbp_pkg::OUT_NONBRANCH;
      cost    = plain_cost_r;
    end else if (btb_hit) begin
      if (cond_r && predicted != next_r) begin
        outcome = bgbp_pkg::OUT_MISPRED;
        cost    = mispred_cost_r;
        tgt_we  = cmd.resolve && taken;
      end else begin
        outcome = bgbp_pkg::OUT_HIT;
        cost    = hit_cost_r;
      end
    end else if (taken) begin
      outcome = bgbp_pkg::OUT_MISS;
      cost    = miss_cost_r;
      tag_we  = cmd.resolve;
      tgt_we  = cmd.resolve;
    end else begin
      outcome = bgbp_pkg::OUT_HIT;
      cost    = hit_cost_r;
    end
  end

  logic [SW-1:0] tot_all_r, tot_hit_r, tot_miss_r, tot_mp_r;
  logic [SW-1:0] cost_ext;
  assign cost_ext = SW'(cost);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      pht_r     <= '{default: 2'd0};
      tot_all_r <= '0;
      tot_hit_r <= '0;
      tot_miss_r <= '0;
      tot_mp_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.resolve) begin
        out_valid <= 1'b1;
        if (cond_upd) begin
          pht_r[pidx] <= ctr_upd;
          hist_r      <= HISTORY_BITS'({hist_r, taken});
        end
        tot_all_r <= tot_all_r + cost_ext;
        case (outcome)
          bgbp_pkg::OUT_HIT:     tot_hit_r  <= tot_hit_r + cost_ext;
          bgbp_pkg::OUT_MISS:    tot_miss_r <= tot_miss_r + cost_ext;
          bgbp_pkg::OUT_MISPRED: tot_mp_r   <= tot_mp_r + cost_ext;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_outcome <= outcome;
      out_cost    <= cost;
    end
  end

  assign out_total_cycles     = tot_all_r;
  assign out_total_hit        = tot_hit_r;
  assign out_total_miss       = tot_miss_r;
  assign out_total_mispredict = tot_mp_r;

endmodule

FILE: hdl/btb_gshare_branch_predictor.sv
// ----------------------------------------------------------------------------
// btb_gshare_branch_predictor: branch target buffer with gshare predictor
// grades each retired instruction and keeps running cycle totals
// ----------------------------------------------------------------------------
// Each input transaction is one retired instruction. The block looks it up in
// a direct-mapped BTB (full-address tags), predicts conditional hits with a
// gshare table of 2-bit counters indexed by global history xor low address
// bits, and returns one result transaction: outcome class, cost and four
// wrapping 48-bit totals. One instruction is handled at a time: the block
// captures it with the BTB memory read at the accepting edge, passes a wait
// state, then resolves and writes the result, and only then reopens the
// input, so no new instruction is accepted before the last one is resolved;
// a stalled result holds resolve and thus the input. The totals on the output
// ports are live and match the result while it is shown. BTB valid bits and
// counters clear at reset; no clearing pass is needed. Configuration writes
// are accepted every cycle; unknown indexes are ignored.
module btb_gshare_branch_predictor #(
  parameter int unsigned BTB_ENTRIES  = bgbp_pkg::BTB_ENTRIES,
  parameter int unsigned HISTORY_BITS = bgbp_pkg::HISTORY_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bgbp_pkg::ADDR_W-1:0]    in_instr_address,
  input  logic [bgbp_pkg::LEN_W-1:0]     in_instr_length,
  input  logic                           in_is_branch,
  input  logic                           in_is_conditional,
  input  logic [bgbp_pkg::ADDR_W-1:0]    in_actual_next,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bgbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgbp_pkg::COST_W-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_outcome,
  output logic [bgbp_pkg::COST_W-1:0]    out_cost,
  output logic [bgbp_pkg::SUM_W-1:0]     out_total_cycles,
  output logic [bgbp_pkg::SUM_W-1:0]     out_total_hit,
  output logic [bgbp_pkg::SUM_W-1:0]     out_total_miss,
  output logic [bgbp_pkg::SUM_W-1:0]     out_total_mispredict
);

  bgbp_pkg::dp_cmd_t cmd;

  // configuration always takes writes
  assign cfg_ready = 1'b1;

  bgbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bgbp_dp #(
    .BTB_ENTRIES  (BTB_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_instr_address     (in_instr_address),
    .in_instr_length      (in_instr_length),
    .in_is_branch         (in_is_branch),
    .in_is_conditional    (in_is_conditional),
    .in_actual_next       (in_actual_next),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_outcome          (out_outcome),
    .out_cost             (out_cost),
    .out_total_cycles     (out_total_cycles),
    .out_total_hit        (out_total_hit),
    .out_total_miss       (out_total_miss),
    .out_total_mispredict (out_total_mispredict)
  );

endmodule

FILE: hdl/bgbp_checker.sv
// ----------------------------------------------------------------------------
// bgbp_checker: port-level checks
// result ordering and total bookkeeping seen from the ports
// ----------------------------------------------------------------------------
module bgbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_outcome,
  input logic [47:0] out_total_cycles,
  input logic [47:0] out_total_hit
);

  // one transaction at a time: input closes right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // totals move only when a new result appears
  a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) && !out_valid ##1 !out_valid |-> $stable(out_total_cycles))
    else $error("total changed without result");

  // hit total holds for a non-hit result
  a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_outcome != bgbp_pkg::OUT_HIT |-> $stable(out_total_hit))
    else $error("hit total moved on non-hit");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("result dropped");

endmodule

bind btb_gshare_branch_predictor bgbp_checker u_bgbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_outcome      (out_outcome),
  .out_total_cycles (out_total_cycles),
  .out_total_hit    (out_total_hit)
);

FILE: bench/btb_gshare_branch_predictor_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btb_gshare_branch_predictor_chk: result checker
// mirrors btb, gshare table and totals, compares every result transaction
// ----------------------------------------------------------------------------
module btb_gshare_branch_predictor_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bgbp_pkg::ADDR_W-1:0]    in_instr_address,
  input  logic [bgbp_pkg::LEN_W-1:0]     in_instr_length,
  input  logic                           in_is_branch,
  input  logic                           in_is_conditional,
  input  logic [bgbp_pkg::ADDR_W-1:0]    in_actual_next,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bgbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgbp_pkg::COST_W-1:0]    cfg_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_outcome,
  input  logic [bgbp_pkg::COST_W-1:0]    out_cost,
  input  logic [bgbp_pkg::SUM_W-1:0]     out_total_cycles,
  input  logic [bgbp_pkg::SUM_W-1:0]     out_total_hit,
  input  logic [bgbp_pkg::SUM_W-1:0]     out_total_miss,
  input  logic [bgbp_pkg::SUM_W-1:0]     out_total_mispredict,
  output int                             errors,
  output int                             pending
);

  localparam int unsigned AW   = bgbp_pkg::ADDR_W;
  localparam int unsigned CW   = bgbp_pkg::COST_W;
  localparam int unsigned SW   = bgbp_pkg::SUM_W;
  localparam int unsigned HB   = bgbp_pkg::HISTORY_BITS;
  localparam int unsigned NBTB = bgbp_pkg::BTB_ENTRIES;

  typedef struct packed {
    bgbp_pkg::outcome_t outcome;
    logic [CW-1:0]      cost;
    logic [SW-1:0]      all, hit, miss, mis;
  } grade_t;

  grade_t            grades_q[$];
  logic [CW-1:0]     cost_tab[4];
  logic [AW-1:0]     tag_m[NBTB];
  logic [AW-1:0]     tgt_m[NBTB];
  logic              vld_m[NBTB];
  logic [1:0]        ctr_m[1 << HB];
  logic [HB-1:0]     hist_m;
  logic [SW-1:0]     s_all, s_hit, s_miss, s_mis;

  function automatic grade_t grade_instr(logic [AW-1:0] a, logic [bgbp_pkg::LEN_W-1:0] l,
                                         logic br, logic cd, logic [AW-1:0] nx);
    grade_t g;
    logic [AW-1:0] fall, pred;
    logic taken;
    int slot, pi;
    logic [1:0] c;
    fall  = a + AW'(l);
    taken = (nx != fall);
    slot  = int'(a % NBTB);
    if (!br) begin
      g.outcome = bgbp_pkg::OUT_NONBRANCH;
      g.cost    = cost_tab[bgbp_pkg::REG_PLAIN];
    end else if (vld_m[slot] && tag_m[slot] == a) begin
      if (cd) begin
        pi   = int'(hist_m ^ a[HB-1:0]);
        c    = ctr_m[pi];
        pred = (c >= 2) ? tgt_m[slot] : fall;
        if (taken && c < 3) c++;
        else if (!taken && c > 0) c--;
        ctr_m[pi] = c;
        hist_m = HB'({hist_m, taken});
        if (pred == nx) begin
          g.outcome = bgbp_pkg::OUT_HIT;
          g.cost    = cost_tab[bgbp_pkg::REG_HIT];
        end else begin
          g.outcome = bgbp_pkg::OUT_MISPRED;
          g.cost    = cost_tab[bgbp_pkg::REG_MISPREDICT];
          if (taken) tgt_m[slot] = nx;
        end
      end else begin
        g.outcome = bgbp_pkg::OUT_HIT;
        g.cost    = cost_tab[bgbp_pkg::REG_HIT];
      end
    end else if (taken) begin
      tag_m[slot] = a;
      tgt_m[slot] = nx;
      vld_m[slot] = 1'b1;
      g.outcome   = bgbp_pkg::OUT_MISS;
      g.cost      = cost_tab[bgbp_pkg::REG_MISS];
    end else begin
      g.outcome = bgbp_pkg::OUT_HIT;
      g.cost    = cost_tab[bgbp_pkg::REG_HIT];
    end
    s_all = s_all + SW'(g.cost);
    case (g.outcome)
      bgbp_pkg::OUT_HIT:     s_hit  = s_hit + SW'(g.cost);
      bgbp_pkg::OUT_MISS:    s_miss = s_miss + SW'(g.cost);
      bgbp_pkg::OUT_MISPRED: s_mis  = s_mis + SW'(g.cost);
      default: ;
    endcase
    g.all = s_all; g.hit = s_hit; g.miss = s_miss; g.mis = s_mis;
    return g;
  endfunction

  always @(posedge clk) begin
    grade_t e, act;
    if (!rst_n) begin
      cost_tab[bgbp_pkg::REG_PLAIN]      <= bgbp_pkg::PLAIN_COST_RST;
      cost_tab[bgbp_pkg::REG_HIT]        <= bgbp_pkg::HIT_COST_RST;
      cost_tab[bgbp_pkg::REG_MISS]       <= bgbp_pkg::MISS_COST_RST;
      cost_tab[bgbp_pkg::REG_MISPREDICT] <= bgbp_pkg::MISPREDICT_COST_RST;
      for (int i = 0; i < NBTB; i++) vld_m[i] = 1'b0;
      for (int i = 0; i < (1 << HB); i++) ctr_m[i] = '0;
      hist_m = '0;
      s_all = '0; s_hit = '0; s_miss = '0; s_mis = '0;
      errors <= 0;
      grades_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cost_tab[cfg_index] <= cfg_data;
      if (in_valid && in_ready)
        grades_q.push_back(grade_instr(in_instr_address, in_instr_length, in_is_branch,
                                       in_is_conditional, in_actual_next));
      if (out_valid && out_ready) begin
        act = '{bgbp_pkg::outcome_t'(out_outcome), out_cost, out_total_cycles,
                out_total_hit, out_total_miss, out_total_mispredict};
        if (grades_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction %p", act);
        end else begin
          e = grades_q.pop_front();
          if (e !== act) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %p actual %p", e, act);
          end
        end
      end
      pending <= grades_q.size();
    end
  end

endmodule

FILE: bench/btb_gshare_branch_predictor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btb_gshare_branch_predictor_tb: testbench top
// drives instruction and cost register traffic, gives the verdict
// ----------------------------------------------------------------------------
module btb_gshare_branch_predictor_tb;

  localparam int unsigned AW = bgbp_pkg::ADDR_W;
  localparam int unsigned LW = bgbp_pkg::LEN_W;
  localparam int unsigned CW = bgbp_pkg::COST_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [AW-1:0] in_instr_address = '0, in_actual_next = '0;
  logic [LW-1:0] in_instr_length = '0;
  logic in_is_branch = 1'b0, in_is_conditional = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [bgbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] out_outcome;
  logic [CW-1:0] out_cost;
  logic [bgbp_pkg::SUM_W-1:0] out_total_cycles, out_total_hit, out_total_miss;
  logic [bgbp_pkg::SUM_W-1:0] out_total_mispredict;
  int errors, pending;

  int send_idle_pct, recv_stall_pct; // per-phase idling odds
  logic hold_req = 1'b0;             // stimulus asks for one long hold-off
  logic hold_req_d = 1'b0;
  int hold_cnt = 0;                  // receiver hold-off in cycles
  logic [AW-1:0] hot_addr[8];        // small pool so the btb gets hits

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  btb_gshare_branch_predictor u_top (.*);

  btb_gshare_branch_predictor_chk u_chk (.*);

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    hold_req_d <= hold_req;
    if (hold_req && !hold_req_d) begin
      hold_cnt  <= 200;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one register write, only while nothing is in flight
  task automatic write_cost(bgbp_pkg::reg_idx_t idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // offer one instruction transaction and wait for acceptance
  task automatic send_instr(logic [AW-1:0] a, logic [LW-1:0] l,
                            logic br, logic cd, logic [AW-1:0] nx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_instr_address  <= a;
    in_instr_length   <= l;
    in_is_branch      <= br;
    in_is_conditional <= cd;
    in_actual_next    <= nx;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // mostly branches on a few hot addresses so the gshare table trains
  task automatic random_instr();
    logic [AW-1:0] a, nx;
    logic [LW-1:0] l;
    int k;
    k  = $urandom_range(99);
    a  = (k < 80) ? hot_addr[$urandom_range(7)] : AW'({$urandom, $urandom});
    l  = LW'($urandom_range(15));
    case ($urandom_range(3))
      0:       nx = a + AW'(l);                            // not taken
      1:       nx = AW'({$urandom, $urandom});             // wild target
      default: nx = {a[AW-1:12], 12'h0} + AW'({a[5:0], 6'h0}); // stable target
    endcase
    send_instr(a, l, k < 90, $urandom_range(3) != 0, nx);
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 8; i++) hot_addr[i] = AW'({$urandom, $urandom});
    hot_addr[7] = '1; // fall-through wraps past the top
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every outcome, wrap, zero length
    send_instr('0, '0, 1'b0, 1'b1, '0);                  // non-branch marked conditional
    send_instr('1, 4'hf, 1'b0, 1'b0, '1);
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h14);        // btb miss, not taken, graded as hit
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h800);       // btb miss, fills
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h800);       // counter low: mispredict
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h800);
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h800);
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h900);       // other target, counter still low: mispredict
    send_instr(48'h10, 4'd4, 1'b1, 1'b1, 48'h14);        // not taken
    send_instr(48'h10, 4'd4, 1'b1, 1'b0, 48'h1234);      // unconditional hit
    send_instr('1, 4'd1, 1'b1, 1'b0, '0);                // wraps to zero: not taken
    send_instr('1, 4'd2, 1'b1, 1'b1, 48'h5);             // taken past the wrap
    send_instr(48'h7, 4'd0, 1'b1, 1'b1, 48'h7);          // zero length, not taken
    send_instr(48'h7, 4'd0, 1'b1, 1'b0, 48'haaaa_5555_aaaa);
    send_instr(48'h47, 4'd0, 1'b1, 1'b0, 48'h5555_aaaa_5555); // same slot, other tag
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_cost(bgbp_pkg::REG_PLAIN, 4'd0); write_cost(bgbp_pkg::REG_HIT, 4'd15);
          write_cost(bgbp_pkg::REG_MISS, 4'd0); write_cost(bgbp_pkg::REG_MISPREDICT, 4'd15);
        end
        1: begin
          write_cost(bgbp_pkg::REG_PLAIN, 4'd15); write_cost(bgbp_pkg::REG_HIT, 4'd0);
          write_cost(bgbp_pkg::REG_MISS, 4'd15); write_cost(bgbp_pkg::REG_MISPREDICT, 4'd0);
        end
        default: for (int r = 0; r < 4; r++)
          write_cost(bgbp_pkg::reg_idx_t'(r), CW'($urandom_range(15)));
      endcase
      cfg_valid <= 1'b0;
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        3: begin send_idle_pct = 32; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 2) hold_req <= 1'b1; // block fills and stalls its input
      for (int i = 0; i < 130; i++) begin
        random_instr();
        if (i == 60) drain(); // sender pauses until all results are back
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
